>>> rtl/core/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types, widths and tables for the tick count to calendar converter.
// ----------------------------------------------------------------------------
package tcf_pkg;

	localparam int DVD_W  = 63;  // dividend width of the serial divider
	localparam int DSR_W  = 24;  // divisor and remainder width
	localparam int CNT_W  = 6;   // step counter width
	localparam int YEAR_W = 15;

	// year before the epoch year, the base of the year estimate
	localparam logic [YEAR_W-1:0] EPOCH_Y1 = 15'd1600;

	typedef struct packed {
		logic             go;
		logic [CNT_W-1:0] nbits;
		logic [DSR_W-1:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic [YEAR_W-1:0] y1;
		logic [8:0]        rem366;
		logic [8:0]        q100;
		logic [6:0]        r100;
		logic [6:0]        q400;
		logic [8:0]        r400;
	} cal_in_t;

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
		logic [4:0] len;
		unique case (m)
			4'd0:    len = 5'd31;
			4'd1:    len = leap ? 5'd29 : 5'd28;
			4'd2:    len = 5'd31;
			4'd3:    len = 5'd30;
			4'd4:    len = 5'd31;
			4'd5:    len = 5'd30;
			4'd6:    len = 5'd31;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd30;
			4'd9:    len = 5'd31;
			4'd10:   len = 5'd30;
			4'd11:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

>>> rtl/core/tcf_serdiv.sv
// ----------------------------------------------------------------------------
// tcf_serdiv
// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned; after nbits steps the quotient sits in the low bits.
// ----------------------------------------------------------------------------
module tcf_serdiv (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tcf_pkg::div_cmd_t          cmd,
	input  logic [tcf_pkg::DVD_W-1:0]  dividend,
	output logic [tcf_pkg::DVD_W-1:0]  quotient,
	output logic [tcf_pkg::DSR_W-1:0]  remainder,
	output tcf_pkg::div_stat_t         stat
);
	import tcf_pkg::*;

	logic [DVD_W-1:0] d_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, d_q[DVD_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.go) begin
				run_q <= 1'b1;
				cnt_q <= cmd.nbits;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			d_q   <= dividend;
			rem_q <= '0;
			dsr_q <= cmd.divisor;
		end else if (run_q) begin
			d_q   <= {d_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
		end
	end

	assign quotient   = d_q;
	assign remainder  = rem_q;
	assign stat.busy  = run_q;
	assign stat.done  = done_q;

`ifndef SYNTHESIS
	a_no_go_while_running: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> !run_q) else $error("divider restarted mid-run");
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q && $past(run_q)) else $error("done without a run");
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < dsr_q) else $error("remainder not reduced");
`endif

endmodule

>>> rtl/core/tcf_calendar.sv
// ----------------------------------------------------------------------------
// tcf_calendar
// Corrects the year estimate, steps whole years off the day count, then
// walks the month lengths to give year, month and day of month.
// ----------------------------------------------------------------------------
module tcf_calendar (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  tcf_pkg::cal_in_t            opnd,
	output logic [tcf_pkg::YEAR_W-1:0]  year,
	output logic [3:0]                  month,
	output logic [4:0]                  day_of_month,
	output logic                        done
);
	import tcf_pkg::*;

	// common years up to the year before the epoch year
	localparam logic [15:0] COMMON_BASE = 16'd1212;

	typedef enum logic [1:0] {
		C_IDLE,
		C_ADJ,
		C_YEAR,
		C_MONTH
	} cstate_t;

	cstate_t           state_q;
	logic [15:0]       days_q;
	logic [YEAR_W-1:0] year_q;
	logic [1:0]        m4_q;
	logic [6:0]        m100_q;
	logic [8:0]        m400_q;
	logic [3:0]        mon_q;
	logic              done_q;
	logic              leap;
	logic [8:0]        ylen;
	logic [4:0]        mlen;

	always_comb begin
		leap = (m4_q == 2'd0) && ((m100_q != 7'd0) || (m400_q == 9'd0));
		ylen = leap ? 9'd366 : 9'd365;
		mlen = month_len(leap, mon_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			days_q  <= '0;
			year_q  <= '0;
			m4_q    <= '0;
			m100_q  <= '0;
			m400_q  <= '0;
			mon_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (go) begin
						// remainder of days/366 plus common years, first half
						days_q  <= 16'(opnd.y1) - 16'(opnd.y1 >> 2) - COMMON_BASE
						           + 16'(opnd.rem366);
						year_q  <= opnd.y1 + YEAR_W'(1);
						m4_q    <= opnd.y1[1:0] + 2'd1;
						m100_q  <= (opnd.r100 == 7'd99) ? 7'd0 : opnd.r100 + 7'd1;
						m400_q  <= (opnd.r400 == 9'd399) ? 9'd0 : opnd.r400 + 9'd1;
						state_q <= C_ADJ;
					end
				end
				C_ADJ: begin
					days_q  <= days_q + 16'(opnd.q100) - 16'(opnd.q400);
					state_q <= C_YEAR;
				end
				C_YEAR: begin
					if (days_q >= 16'(ylen)) begin
						days_q <= days_q - 16'(ylen);
						year_q <= year_q + YEAR_W'(1);
						m4_q   <= m4_q + 2'd1;
						m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
						m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
					end else begin
						mon_q   <= 4'd0;
						state_q <= C_MONTH;
					end
				end
				C_MONTH: begin
					if ((mon_q < 4'd11) && (days_q >= 16'(mlen))) begin
						days_q <= days_q - 16'(mlen);
						mon_q  <= mon_q + 4'd1;
					end else begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign year         = year_q;
	assign month        = mon_q + 4'd1;
	assign day_of_month = days_q[4:0] + 5'd1;
	assign done         = done_q;

endmodule

>>> rtl/core/tick_count_to_calendar_fields.sv
// ----------------------------------------------------------------------------
// tick_count_to_calendar_fields
// Converts a count of 100 ns ticks since 1601-01-01 00:00 into Gregorian
// date and time fields.
// ----------------------------------------------------------------------------
// A conversion is started by raising start while busy is low; tick_count is
// taken at that edge. The result appears one cycle later than the last step
// of the work, on the output ports for a single cycle with done high, and
// must be captured then. The work falls first to the shared
// one-bit-per-cycle divider, which runs nine divisions in turn (by ticks per
// second, seconds per day, ticks per millisecond, seconds per hour and per
// minute, days per week, 366 and the century divisors of the year), then to
// handing over to and back from the calendar stage, which steps the year
// estimate forward one year per cycle and walks the months one per cycle
// (up to 11 steps). busy is low again in the cycle that done is high, so
// the next start may follow.
module tick_count_to_calendar_fields (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [62:0] tick_count,
	output logic        busy,
	output logic        done,
	output logic [9:0]  millisecond,
	output logic [5:0]  second,
	output logic [5:0]  minute,
	output logic [4:0]  hour,
	output logic [2:0]  weekday,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month,
	output logic [14:0] year
);
	import tcf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_CAL_GO,
		ST_CAL_WAIT
	} state_t;

	typedef enum logic [3:0] {
		OP_SEC,
		OP_DAY,
		OP_MS,
		OP_HOUR,
		OP_MIN,
		OP_WDAY,
		OP_YEST,
		OP_Q100,
		OP_Q400
	} op_t;

	state_t            state_q;
	op_t               op_q;
	logic [DVD_W-1:0]  tick_q;
	logic [39:0]       secs_q;
	logic [23:0]       tr_q;
	logic [23:0]       days_q;
	logic [16:0]       sid_q;
	logic [11:0]       rmin_q;
	cal_in_t           cal_q;
	logic              done_q;
	logic [9:0]        ms_q;
	logic [5:0]        sec_q;
	logic [5:0]        min_q;
	logic [4:0]        hour_q;
	logic [2:0]        wday_q;
	logic [4:0]        dom_q;
	logic [3:0]        mon_q;
	logic [YEAR_W-1:0] year_q;

	div_cmd_t          div_cmd;
	div_stat_t         div_stat;
	logic [DVD_W-1:0]  dividend;
	logic [DVD_W-1:0]  quot;
	logic [DSR_W-1:0]  rem;
	logic              cal_go;
	logic              cal_done;
	logic [YEAR_W-1:0] cal_year;
	logic [3:0]        cal_month;
	logic [4:0]        cal_dom;

	// operands of each division, dividend left-aligned
	always_comb begin
		div_cmd.go = (state_q == ST_DIV_GO);
		unique case (op_q)
			OP_SEC: begin
				dividend        = tick_q;
				div_cmd.nbits   = 6'd63;
				div_cmd.divisor = 24'd10000000;
			end
			OP_DAY: begin
				dividend        = {secs_q, 23'b0};
				div_cmd.nbits   = 6'd40;
				div_cmd.divisor = 24'd86400;
			end
			OP_MS: begin
				dividend        = {tr_q, 39'b0};
				div_cmd.nbits   = 6'd24;
				div_cmd.divisor = 24'd10000;
			end
			OP_HOUR: begin
				dividend        = {sid_q, 46'b0};
				div_cmd.nbits   = 6'd17;
				div_cmd.divisor = 24'd3600;
			end
			OP_MIN: begin
				dividend        = {rmin_q, 51'b0};
				div_cmd.nbits   = 6'd12;
				div_cmd.divisor = 24'd60;
			end
			OP_WDAY: begin
				// the epoch day was a monday
				dividend        = {days_q + 24'd1, 39'b0};
				div_cmd.nbits   = 6'd24;
				div_cmd.divisor = 24'd7;
			end
			OP_YEST: begin
				dividend        = {days_q, 39'b0};
				div_cmd.nbits   = 6'd24;
				div_cmd.divisor = 24'd366;
			end
			OP_Q100: begin
				dividend        = {cal_q.y1, 48'b0};
				div_cmd.nbits   = 6'd15;
				div_cmd.divisor = 24'd100;
			end
			OP_Q400: begin
				dividend        = {cal_q.y1, 48'b0};
				div_cmd.nbits   = 6'd15;
				div_cmd.divisor = 24'd400;
			end
			default: begin
				dividend        = tick_q;
				div_cmd.nbits   = 6'd63;
				div_cmd.divisor = 24'd10000000;
			end
		endcase
	end

	assign cal_go = (state_q == ST_CAL_GO);

	tcf_serdiv u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (div_cmd),
		.dividend  (dividend),
		.quotient  (quot),
		.remainder (rem),
		.stat      (div_stat)
	);

	tcf_calendar u_cal (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (cal_go),
		.opnd         (cal_q),
		.year         (cal_year),
		.month        (cal_month),
		.day_of_month (cal_dom),
		.done         (cal_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_SEC;
			tick_q  <= '0;
			secs_q  <= '0;
			tr_q    <= '0;
			days_q  <= '0;
			sid_q   <= '0;
			rmin_q  <= '0;
			cal_q   <= '0;
			done_q  <= 1'b0;
			ms_q    <= '0;
			sec_q   <= '0;
			min_q   <= '0;
			hour_q  <= '0;
			wday_q  <= '0;
			dom_q   <= '0;
			mon_q   <= '0;
			year_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						tick_q  <= tick_count;
						op_q    <= OP_SEC;
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_stat.done) begin
						state_q <= ST_DIV_GO;
						unique case (op_q)
							OP_SEC: begin
								secs_q <= quot[39:0];
								tr_q   <= rem;
								op_q   <= OP_DAY;
							end
							OP_DAY: begin
								days_q <= quot[23:0];
								sid_q  <= rem[16:0];
								op_q   <= OP_MS;
							end
							OP_MS: begin
								ms_q <= quot[9:0];
								op_q <= OP_HOUR;
							end
							OP_HOUR: begin
								hour_q <= quot[4:0];
								rmin_q <= rem[11:0];
								op_q   <= OP_MIN;
							end
							OP_MIN: begin
								min_q <= quot[5:0];
								sec_q <= rem[5:0];
								op_q  <= OP_WDAY;
							end
							OP_WDAY: begin
								wday_q <= rem[2:0];
								op_q   <= OP_YEST;
							end
							OP_YEST: begin
								cal_q.y1     <= EPOCH_Y1 + quot[YEAR_W-1:0];
								cal_q.rem366 <= rem[8:0];
								op_q         <= OP_Q100;
							end
							OP_Q100: begin
								cal_q.q100 <= quot[8:0];
								cal_q.r100 <= rem[6:0];
								op_q       <= OP_Q400;
							end
							OP_Q400: begin
								cal_q.q400 <= quot[6:0];
								cal_q.r400 <= rem[8:0];
								state_q    <= ST_CAL_GO;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CAL_GO: state_q <= ST_CAL_WAIT;
				ST_CAL_WAIT: begin
					if (cal_done) begin
						year_q  <= cal_year;
						mon_q   <= cal_month;
						dom_q   <= cal_dom;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign millisecond  = ms_q;
	assign second       = sec_q;
	assign minute       = min_q;
	assign hour         = hour_q;
	assign weekday      = wday_q;
	assign day_of_month = dom_q;
	assign month        = mon_q;
	assign year         = year_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while still busy");
	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transaction not taken");
	a_div_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == ST_DIV_WAIT) else $error("divider running out of turn");
	a_fields_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month != 4'd0) && (month <= 4'd12) && (second < 6'd60) && (weekday < 3'd7))
		else $error("field out of range");
`endif

endmodule

>>> tb/sv/tick_count_to_calendar_fields_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_count_to_calendar_fields_test
// Self-checking bench for the tick count to calendar converter. Directed
// counts hit the epoch, the largest count, millisecond and day rollovers and
// the century leap-year rules; random counts mix raw 63-bit values with
// dates built field by field, many of them on month and year boundaries.
// Every result is checked field by field against a behavioural calendar
// predictor.
// ----------------------------------------------------------------------------
module tick_count_to_calendar_fields_test;

	typedef struct packed {
		logic [9:0]  millisecond;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [2:0]  weekday;
		logic [4:0]  day_of_month;
		logic [3:0]  month;
		logic [14:0] year;
	} calendar_t;

	localparam longint unsigned TICKS_PER_SECOND = 64'd10000000;
	localparam longint unsigned TICKS_PER_MS     = 64'd10000;
	localparam longint unsigned SECONDS_PER_DAY  = 64'd86400;
	localparam int              FIRST_YEAR       = 1601;
	localparam int              LAST_FULL_YEAR   = 30827;
	localparam int              RANDOM_ITEMS     = 1680;
	localparam int              DRAIN_CYCLES     = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [62:0] tick_count = '0;
	logic        busy;
	logic        done;
	logic [9:0]  millisecond;
	logic [5:0]  second;
	logic [5:0]  minute;
	logic [4:0]  hour;
	logic [2:0]  weekday;
	logic [4:0]  day_of_month;
	logic [3:0]  month;
	logic [14:0] year;

	logic [62:0] queued_ticks[$];
	int          queued_gaps[$];
	calendar_t   awaited_dates[$];
	int          idle_left = 0;
	int          total_items = 0;
	int          accepted = 0;
	int          converted = 0;
	int          errors = 0;
	int          leap_days_seen = 0;
	int          lowest_year = 32767;
	int          highest_year = 0;

	tick_count_to_calendar_fields DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.tick_count   (tick_count),
		.busy         (busy),
		.done         (done),
		.millisecond  (millisecond),
		.second       (second),
		.minute       (minute),
		.hour         (hour),
		.weekday      (weekday),
		.day_of_month (day_of_month),
		.month        (month),
		.year         (year)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit is_leap(input longint unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	// leap years in 1..y
	function automatic longint unsigned leaps_through(input longint unsigned y);
		return y / 4 - y / 100 + y / 400;
	endfunction

	// months counted from 1
	function automatic longint unsigned days_in_month(input bit leap, input int m);
		case (m)
			2:              return leap ? 64'd29 : 64'd28;
			4, 6, 9, 11:    return 64'd30;
			default:        return 64'd31;
		endcase
	endfunction

	function automatic calendar_t calendar_of(input logic [62:0] ticks);
		calendar_t        c;
		longint unsigned  t, secs, days, sid, n, yr, common, len;
		bit               lp;
		int               m;
		t    = 64'(ticks);
		secs = t / TICKS_PER_SECOND;
		days = secs / SECONDS_PER_DAY;
		sid  = secs % SECONDS_PER_DAY;
		c.millisecond = 10'((t % TICKS_PER_SECOND) / TICKS_PER_MS);
		c.hour        = 5'(sid / 3600);
		c.minute      = 6'((sid % 3600) / 60);
		c.second      = 6'(sid % 60);
		// the epoch day was a monday
		c.weekday     = 3'((days + 1) % 7);
		// estimate from 366-day years, then add back the days of common years
		n      = days / 366;
		yr     = 64'(FIRST_YEAR) + n;
		common = ((yr - 1) - leaps_through(yr - 1)) - (64'd1600 - leaps_through(64'd1600));
		days   = days - n * 366 + common;
		forever begin
			len = is_leap(yr) ? 64'd366 : 64'd365;
			if (days < len)
				break;
			days -= len;
			yr++;
		end
		lp = is_leap(yr);
		m  = 1;
		while (m < 12 && days >= days_in_month(lp, m)) begin
			days -= days_in_month(lp, m);
			m++;
		end
		c.day_of_month = 5'(days + 1);
		c.month        = 4'(m);
		c.year         = 15'(yr);
		return c;
	endfunction

	function automatic logic [62:0] ticks_at(input int y, input int mo, input int d,
			input int h, input int mi, input int s, input int ms, input int sub);
		longint unsigned days, secs;
		int              k;
		days = 64'(365 * (y - FIRST_YEAR)) + leaps_through(64'(y - 1))
			- leaps_through(64'd1600);
		for (k = 1; k < mo; k++)
			days += days_in_month(is_leap(64'(y)), k);
		days += 64'(d - 1);
		secs = days * SECONDS_PER_DAY + 64'(h * 3600 + mi * 60 + s);
		return 63'((secs * 1000 + 64'(ms)) * TICKS_PER_MS + 64'(sub));
	endfunction

	// years weighted towards the leap rules and the early centuries
	function automatic int pick_year();
		case ($urandom_range(0, 4))
			0:       return 1700 + 100 * $urandom_range(0, 291);
			1:       return 2000 + 400 * $urandom_range(0, 72);
			2:       return 1604 + 4 * $urandom_range(0, 7305);
			3:       return $urandom_range(FIRST_YEAR, 2500);
			default: return $urandom_range(FIRST_YEAR, LAST_FULL_YEAR);
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 80)
			return $urandom_range(1, 300);
		else if (r < 95)
			return $urandom_range(300, 420);
		else
			return $urandom_range(420, 900);
	endfunction

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// driver: a transaction is taken when start is high and busy is low
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			tick_count <= '0;
			idle_left  <= 0;
		end else begin
			if (start && !busy) begin
				awaited_dates.push_back(calendar_of(tick_count));
				accepted++;
			end
			if (!start || !busy) begin
				if (idle_left != 0) begin
					start     <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (queued_ticks.size() != 0) begin
					start      <= 1'b1;
					tick_count <= queued_ticks.pop_front();
					idle_left  <= queued_gaps.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		calendar_t want;
		if (arst_n && done) begin
			if (awaited_dates.size() == 0) begin
				$display("%0t: result with no transaction outstanding, year %0d", $time, year);
				errors++;
			end else begin
				want = awaited_dates.pop_front();
				check_field("millisecond", 64'(want.millisecond), 64'(millisecond));
				check_field("second", 64'(want.second), 64'(second));
				check_field("minute", 64'(want.minute), 64'(minute));
				check_field("hour", 64'(want.hour), 64'(hour));
				check_field("weekday", 64'(want.weekday), 64'(weekday));
				check_field("day_of_month", 64'(want.day_of_month), 64'(day_of_month));
				check_field("month", 64'(want.month), 64'(month));
				check_field("year", 64'(want.year), 64'(year));
				converted++;
				if (want.month == 4'd2 && want.day_of_month == 5'd29)
					leap_days_seen++;
				if (int'(want.year) < lowest_year)
					lowest_year = int'(want.year);
				if (int'(want.year) > highest_year)
					highest_year = int'(want.year);
			end
		end
	end

	initial begin : stimulus
		int          i, blk, y, mo, dim;
		bit          calm;
		logic [62:0] t;

		// epoch, sub-millisecond and second rollovers, the largest counts
		queued_ticks.push_back(63'd0);
		queued_ticks.push_back(63'd9999);
		queued_ticks.push_back(63'd10000);
		queued_ticks.push_back(63'd9999999);
		queued_ticks.push_back(63'd10000000);
		queued_ticks.push_back(63'h7FFF_FFFF_FFFF_FFFF);
		queued_ticks.push_back(63'h4000_0000_0000_0000);
		queued_ticks.push_back(63'h3FFF_FFFF_FFFF_FFFF);
		queued_ticks.push_back(63'h5555_5555_5555_5555);
		queued_ticks.push_back(63'h2AAA_AAAA_AAAA_AAAA);
		// year ends and the century leap rules
		queued_ticks.push_back(ticks_at(1601, 12, 31, 23, 59, 59, 999, 9999));
		queued_ticks.push_back(ticks_at(1602, 1, 1, 0, 0, 0, 0, 0));
		queued_ticks.push_back(ticks_at(1604, 2, 29, 12, 30, 30, 500, 0));
		queued_ticks.push_back(ticks_at(1604, 12, 31, 23, 59, 59, 999, 9999));
		queued_ticks.push_back(ticks_at(1700, 2, 28, 23, 59, 59, 999, 9999));
		queued_ticks.push_back(ticks_at(1700, 3, 1, 0, 0, 0, 0, 0));
		queued_ticks.push_back(ticks_at(1900, 3, 1, 0, 0, 0, 0, 0));
		queued_ticks.push_back(ticks_at(2000, 2, 29, 23, 59, 59, 999, 9999));
		queued_ticks.push_back(ticks_at(2000, 12, 31, 0, 0, 0, 0, 0));
		queued_ticks.push_back(ticks_at(2100, 3, 1, 1, 1, 1, 1, 1));
		queued_ticks.push_back(ticks_at(30828, 1, 1, 0, 0, 0, 0, 0));

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: t = 63'({$urandom, $urandom});
				3, 4, 5: begin
					y   = pick_year();
					mo  = $urandom_range(1, 12);
					dim = int'(days_in_month(is_leap(64'(y)), mo));
					t   = ticks_at(y, mo, $urandom_range(1, dim), $urandom_range(0, 23),
						$urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(0, 999),
						$urandom_range(0, 9999));
				end
				6, 7: begin
					// last tick of a month, or the first of the next
					y   = pick_year();
					mo  = $urandom_range(0, 2) == 0 ? 12 : $urandom_range(1, 12);
					dim = int'(days_in_month(is_leap(64'(y)), mo));
					t   = ticks_at(y, mo, dim, 23, 59, 59, 999, 9999)
						+ 63'($urandom_range(0, 1));
				end
				8:       t = 63'({$urandom} >> $urandom_range(0, 31));
				default: t = 63'h7FFF_FFFF_FFFF_FFFF
					- 63'({$urandom, $urandom} >> $urandom_range(8, 63));
			endcase
			queued_ticks.push_back(t);
		end
		total_items = queued_ticks.size();

		// every third block of forty runs back to back
		for (i = 0; i < total_items; i++) begin
			blk  = i / 40;
			calm = (blk % 3 == 2);
			queued_gaps.push_back(calm ? 0 : pick_gap());
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (accepted < total_items || awaited_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d conversions checked, years %0d to %0d", converted, lowest_year,
			highest_year);
		$display("%0d results fell on 29 February, %0d mismatching fields", leap_days_seen,
			errors);
		if (errors == 0 && awaited_dates.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : watchdog
		#100ms;
		$display("timeout with %0d of %0d transactions taken", accepted, total_items);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/tcf_pkg.sv
rtl/core/tcf_serdiv.sv
rtl/core/tcf_calendar.sv
rtl/core/tick_count_to_calendar_fields.sv
tb/sv/tick_count_to_calendar_fields_test.sv
